>>> src/escape_time_fractal_pixel_macros.svh
// Assertion macros for the escape-time fractal pixel block.
// Included by the top level only; the including module must have clk and rst.
`ifndef ESCAPE_TIME_FRACTAL_PIXEL_MACROS_SVH
`define ESCAPE_TIME_FRACTAL_PIXEL_MACROS_SVH

// same-cycle implication
`define ETFP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("etfp assertion failed");

// next-cycle implication
`define ETFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("etfp assertion failed");

`endif

>>> src/etfp_pkg.sv
// Shared types, register codes and helpers for the escape-time fractal pixel block.
// No dependencies.
package etfp_pkg;

  localparam int unsigned IterW  = 12;
  localparam int unsigned CoordW = 10;
  localparam int unsigned SeqW   = 2;   // ring holds at most three transactions
  localparam int unsigned QuotW  = 8;   // i*250/max_iter < 250 when escaped
  localparam int unsigned NumW   = 20;  // 4095*250 fits

  typedef enum logic [2:0] {
    REG_X_ORIGIN   = 3'd0,
    REG_X_STEP     = 3'd1,
    REG_Y_ORIGIN   = 3'd2,
    REG_Y_STEP     = 3'd3,
    REG_MAX_ITER   = 3'd4,
    REG_START_REAL = 3'd5,
    REG_START_IMAG = 3'd6,
    REG_NONE       = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] zr;
    logic signed [31:0] zi;
    logic signed [31:0] cr;
    logic signed [31:0] ci;
    logic [IterW-1:0]   cnt;
    logic               done;
    logic [SeqW-1:0]    seq;
    logic [CoordW-1:0]  col;
    logic [CoordW-1:0]  lin;
  } item_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF)       r = 32'sh7FFF_FFFF;
    else if (v < -64'sh0000_0000_8000_0000) r = 32'sh8000_0000;
    else                                    r = v[31:0];
    return r;
  endfunction

endpackage

>>> src/escape_time_fractal_pixel.sv
// Escape-time fractal pixel: Mandelbrot iteration with in-order result delivery.
// Path: setup stages A and B (entry waits for a free ring slot), a ring pass per
//   iteration plus the exit test, waits behind older pixels, then color stages.
// Sharing: three pixels share the 3-stage iteration ring that sets the pixel rate;
//   a new pixel enters only when a ring slot is free.
// Reset (rst, synchronous, active high) empties all stages and loads register
//   defaults: origins -2.0, steps 2^-8, max_iter 50, start point zero.
// Depends on etfp_pkg and escape_time_fractal_pixel_macros.svh.
`include "escape_time_fractal_pixel_macros.svh"

module escape_time_fractal_pixel
  import etfp_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 28
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  // pixel input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CoordW-1:0]    column,
  input  logic [CoordW-1:0]    line,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CoordW-1:0]    out_column,
  output logic [CoordW-1:0]    out_line,
  output logic [IterW-1:0]     iterations,
  output logic                 escaped,
  output logic [23:0]          colour
);

  // |z|^2 bound of 4 at twice the fraction bits
  localparam logic [63:0] EscLimit = 64'd4 << (2 * FRAC_BITS);
  localparam int unsigned DivN     = QuotW + 2;   // load, 8 quotient bits, color

  // ---------------------------------------------------------------- config
  logic signed [31:0] x_origin, x_step, y_origin, y_step, start_real, start_imag;
  logic [IterW-1:0]   max_iter;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_origin   <= -32'sd536870912;
      x_step     <= 32'sd1048576;
      y_origin   <= -32'sd536870912;
      y_step     <= 32'sd1048576;
      max_iter   <= 12'd50;
      start_real <= '0;
      start_imag <= '0;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_X_ORIGIN:   x_origin   <= cfg_data;
        REG_X_STEP:     x_step     <= cfg_data;
        REG_Y_ORIGIN:   y_origin   <= cfg_data;
        REG_Y_STEP:     y_step     <= cfg_data;
        REG_MAX_ITER:   max_iter   <= cfg_data[IterW-1:0];
        REG_START_REAL: start_real <= cfg_data;
        REG_START_IMAG: start_imag <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- setup
  // Stage A multiplies index by step, stage B adds origin and saturates.
  logic               pav, pbv;
  logic signed [42:0] pa_px, pa_py;
  logic [CoordW-1:0]  pa_col, pa_lin, pb_col, pb_lin;
  logic signed [31:0] pb_cr, pb_ci;
  logic               pa_adv, take;

  // ring registers
  logic               v0, v1, v2;
  item_t              it0, it1, it2;
  item_t              it1_next, it2_next;
  logic signed [63:0] sr0, si0, pr0, diff1, pr1;
  logic [SeqW-1:0]    head, tail;
  logic               exit_now;

  // color pipeline
  logic               div_adv;

  assign take     = pbv && (!v2 || exit_now);
  assign pa_adv   = !pbv || take;
  assign in_ready = !pav || pa_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      pav <= 1'b0;
      pbv <= 1'b0;
    end else begin
      if (in_ready) pav <= in_valid;
      if (pa_adv)   pbv <= pav;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pa_px  <= $signed({1'b0, column}) * x_step;
      pa_py  <= $signed({1'b0, line}) * y_step;
      pa_col <= column;
      pa_lin <= line;
    end
    if (pa_adv && pav) begin
      pb_cr  <= sat32(64'(pa_px) + 64'(x_origin));
      pb_ci  <= sat32(64'(pa_py) + 64'(y_origin));
      pb_col <= pa_col;
      pb_lin <= pa_lin;
    end
  end

  // ---------------------------------------------------------------- ring
  // Stage 0 squares, stage 1 magnitude test, stage 2 update. A finished
  // transaction keeps circulating unchanged until it is the oldest one.
  item_t ring_in;
  item_t new_it;

  always_comb begin
    new_it      = '0;
    new_it.zr   = start_real;
    new_it.zi   = start_imag;
    new_it.cr   = pb_cr;
    new_it.ci   = pb_ci;
    new_it.cnt  = '0;
    new_it.done = 1'b0;
    new_it.seq  = tail;
    new_it.col  = pb_col;
    new_it.lin  = pb_lin;
    ring_in     = take ? new_it : it2;
  end

  assign exit_now = v2 && it2.done && (it2.seq == head) && div_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      head <= '0;
      tail <= '0;
    end else begin
      v0 <= take || (v2 && !exit_now);
      v1 <= v0;
      v2 <= v1;
      if (take)     tail <= tail + 1'b1;
      if (exit_now) head <= head + 1'b1;
    end
  end

  logic [63:0] mag0;
  assign mag0 = sr0 + si0;

  // limit reached or escaped: freeze the transaction
  always_comb begin
    it1_next      = it0;
    it1_next.done = it0.done || (it0.cnt >= max_iter) || (mag0 > EscLimit);
  end

  always_comb begin
    it2_next = it1;
    if (!it1.done) begin
      it2_next.zr  = sat32((diff1 >>> FRAC_BITS) + 64'(it1.cr));
      it2_next.zi  = sat32((pr1 >>> (FRAC_BITS - 1)) + 64'(it1.ci));
      it2_next.cnt = it1.cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    it0 <= ring_in;
    sr0 <= ring_in.zr * ring_in.zr;
    si0 <= ring_in.zi * ring_in.zi;
    pr0 <= ring_in.zr * ring_in.zi;

    it1   <= it1_next;
    diff1 <= sr0 - si0;
    pr1   <= pr0;

    it2 <= it2_next;
  end

  // ---------------------------------------------------------------- color
  // Restoring division of cnt*250 by max_iter, one quotient bit per stage,
  // then cnt*2000 + (quotient << 5) for escaped pixels, zero otherwise.
  logic              dv  [DivN];
  logic [NumW-1:0]   drem[DivN];
  logic [QuotW-1:0]  dq  [DivN];
  logic [IterW-1:0]  dcnt[DivN];
  logic              desc[DivN];
  logic [CoordW-1:0] dcol[DivN];
  logic [CoordW-1:0] dlin[DivN];
  logic [23:0]       dclr;

  assign div_adv = !dv[DivN-1] || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DivN; k++) dv[k] <= 1'b0;
    end else if (div_adv) begin
      dv[0] <= exit_now;
      for (int k = 1; k < DivN; k++) dv[k] <= dv[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (div_adv) begin
      drem[0] <= NumW'(it2.cnt) * NumW'(250);
      dq[0]   <= '0;
      dcnt[0] <= it2.cnt;
      desc[0] <= it2.cnt < max_iter;
      dcol[0] <= it2.col;
      dlin[0] <= it2.lin;
      for (int k = 1; k < DivN; k++) begin
        dcnt[k] <= dcnt[k-1];
        desc[k] <= desc[k-1];
        dcol[k] <= dcol[k-1];
        dlin[k] <= dlin[k-1];
      end
      for (int k = 1; k <= QuotW; k++) begin
        if (drem[k-1] >= (NumW'(max_iter) << (QuotW - k))) begin
          drem[k] <= drem[k-1] - (NumW'(max_iter) << (QuotW - k));
          dq[k]   <= dq[k-1] | (QuotW'(1) << (QuotW - k));
        end else begin
          drem[k] <= drem[k-1];
          dq[k]   <= dq[k-1];
        end
      end
      for (int k = QuotW + 1; k < DivN; k++) begin
        drem[k] <= drem[k-1];
        dq[k]   <= dq[k-1];
      end
      dclr <= desc[DivN-2]
            ? 24'(dcnt[DivN-2]) * 24'd2000 + (24'(dq[DivN-2]) << 5)
            : '0;
    end
  end

  assign out_valid  = dv[DivN-1];
  assign out_column = dcol[DivN-1];
  assign out_line   = dlin[DivN-1];
  assign iterations = dcnt[DivN-1];
  assign escaped    = desc[DivN-1];
  assign colour     = dclr;

  // ---------------------------------------------------------------- checks
  `ETFP_ASSERT_NOW(a_esc_below_limit, out_valid && escaped, iterations < max_iter)
  `ETFP_ASSERT_NEXT(a_held_item_recirculates, v2 && it2.done && !exit_now, v0 && it0.done)
  `ETFP_ASSERT_NOW(a_entry_slot_free, take, !v2 || exit_now)

endmodule

>>> bench/escape_time_fractal_pixel_tb.sv
// Self-checking bench for escape_time_fractal_pixel: directed table, then random views.
// Depends on etfp_pkg and the block's RTL; expected pixels come from a local predictor.
`timescale 1ns / 1ps

module escape_time_fractal_pixel_tb;
  import etfp_pkg::*;

  localparam int unsigned FRAC = 28;
  localparam int unsigned STALL_LIMIT = 60000;  // cycles with no transaction at all
  localparam int unsigned LONG_HOLD = 400;      // receiver back-pressure stretch
  localparam int unsigned DRAIN_WAIT = 40;      // ordering + color stages, with margin
  localparam int unsigned RAND_PHASES = 12;
  localparam int unsigned RAND_PER_PHASE = 115;

  typedef struct packed {
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] lin;
    logic [IterW-1:0]  iter;
    logic              esc;
    logic [23:0]       colour;
  } pixel_result_t;

  // One directed transaction. "typed" rows carry their own expected result.
  typedef struct packed {
    logic [1:0]        view;   // which directed register setting applies
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] lin;
    logic              typed;
    logic [IterW-1:0]  iter;
    logic              esc;
    logic [23:0]       colour;
  } pixel_row_t;

  localparam logic [1:0] VIEW_RESET = 2'd0;  // register defaults
  localparam logic [1:0] VIEW_NOITER = 2'd1; // iteration limit zero
  localparam logic [1:0] VIEW_EXTREME = 2'd2; // saturating coordinates
  localparam logic [1:0] VIEW_DEEP = 2'd3;   // limit 4095, point inside the set

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CoordW-1:0] column = '0;
  logic [CoordW-1:0] line = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CoordW-1:0] out_column;
  logic [CoordW-1:0] out_line;
  logic [IterW-1:0] iterations;
  logic escaped;
  logic [23:0] colour;

  escape_time_fractal_pixel u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .column(column), .line(line),
    .out_valid(out_valid), .out_ready(out_ready), .out_column(out_column),
    .out_line(out_line), .iterations(iterations), .escaped(escaped), .colour(colour)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mirror of the view registers, updated on each accepted config transaction.
  logic signed [31:0] view_x0 = -32'sd536870912;
  logic signed [31:0] view_dx = 32'sd1048576;
  logic signed [31:0] view_y0 = -32'sd536870912;
  logic signed [31:0] view_dy = 32'sd1048576;
  logic [IterW-1:0]   iter_limit = 12'd50;
  logic signed [31:0] seed_re = '0;
  logic signed [31:0] seed_im = '0;

  pixel_result_t pending_pixels[$];
  int unsigned mismatches = 0;
  int unsigned pixels_sent = 0;
  int unsigned pixels_checked = 0;
  int unsigned escaped_seen = 0;
  int unsigned cfg_writes = 0;
  int unsigned idle_cycles = 0;
  bit quiet = 1'b0;       // no idling on either side
  bit hold_request = 1'b0; // receiver should hold off for LONG_HOLD cycles

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Escape-time iteration at Q4.28, squares exact at Q8.56, floor on the shifts.
  function automatic pixel_result_t mandel_pixel(input logic [CoordW-1:0] col,
                                                 input logic [CoordW-1:0] lin);
    pixel_result_t r;
    longint cr, ci, zr, zi, sr, si, nr, ni;
    longint unsigned mag, quot;
    int unsigned i;
    cr = clamp32(longint'(view_x0) + longint'(col) * longint'(view_dx));
    ci = clamp32(longint'(view_y0) + longint'(lin) * longint'(view_dy));
    zr = longint'(seed_re);
    zi = longint'(seed_im);
    i = 0;
    while (i < iter_limit) begin
      sr = zr * zr;
      si = zi * zi;
      mag = longint'(sr) + longint'(si);
      if (mag > (64'd4 << (2 * FRAC))) break;
      nr = clamp32(((sr - si) >>> FRAC) + cr);
      ni = clamp32(((zr * zi) >>> (FRAC - 1)) + ci);
      zr = nr;
      zi = ni;
      i++;
    end
    r.col = col;
    r.lin = lin;
    r.iter = i[IterW-1:0];
    r.esc = (i < iter_limit);
    r.colour = '0;
    if (r.esc) begin
      quot = (longint'(i) * 250) / longint'(iter_limit);
      r.colour = 24'((longint'(i) * 2000) + (quot << 5));
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Config transactions back to back; valid drops once, after the last one.
  task automatic write_view(input logic [31:0] x0, input logic [31:0] dx,
                            input logic [31:0] y0, input logic [31:0] dy,
                            input logic [31:0] lim, input logic [31:0] sre,
                            input logic [31:0] sim);
    logic [31:0] vals[7];
    reg_idx_t idx;
    vals = '{x0, dx, y0, dy, lim, sre, sim};
    for (int k = 0; k < 7; k++) begin
      idx = reg_idx_t'(k);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= vals[k];
      do @(posedge clk); while (!cfg_ready);
      cfg_writes++;
      case (idx)
        REG_X_ORIGIN:   view_x0 = vals[k];
        REG_X_STEP:     view_dx = vals[k];
        REG_Y_ORIGIN:   view_y0 = vals[k];
        REG_Y_STEP:     view_dy = vals[k];
        REG_MAX_ITER:   iter_limit = vals[k][IterW-1:0];
        REG_START_REAL: seed_re = vals[k];
        REG_START_IMAG: seed_im = vals[k];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Sender stops here until every expected pixel is back and the pipe is empty.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Offers one pixel transaction; expectation queued when it is accepted.
  task automatic send_pixel(input logic [CoordW-1:0] col, input logic [CoordW-1:0] lin,
                            input bit typed, input pixel_result_t want);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(12, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    column <= col;
    line <= lin;
    do @(posedge clk); while (!in_ready);
    pending_pixels.push_back(typed ? want : mandel_pixel(col, lin));
    pixels_sent++;
  endtask

  // Receiver: random stalls per transaction, plus one long hold on request.
  initial begin
    int unsigned stall;
    @(negedge rst);
    forever begin
      stall = quiet ? 0 : $urandom_range(12, 0);
      if (hold_request) begin
        stall = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Result checker: field by field against the oldest expectation.
  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected result, column", out_column, -1);
      end else begin
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (escaped) escaped_seen++;
        if (out_column !== want.col) report_mismatch("out_column", out_column, want.col);
        if (out_line !== want.lin) report_mismatch("out_line", out_line, want.lin);
        if (iterations !== want.iter) report_mismatch("iterations", iterations, want.iter);
        if (escaped !== want.esc) report_mismatch("escaped", escaped, want.esc);
        if (colour !== want.colour) report_mismatch("colour", colour, want.colour);
      end
    end
  end

  // Watchdog: any accepted transaction on any channel counts as progress.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog expired with %0d pixels outstanding", pending_pixels.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic pixel_row_t row(input logic [1:0] v, input int c, input int l,
                                     input bit t, input int it, input bit e, input int co);
    pixel_row_t r;
    r.view = v;
    r.col = c[CoordW-1:0];
    r.lin = l[CoordW-1:0];
    r.typed = t;
    r.iter = it[IterW-1:0];
    r.esc = e;
    r.colour = co[23:0];
    return r;
  endfunction

  initial begin
    pixel_row_t rows[$];
    pixel_result_t want;
    logic [1:0] cur_view;
    logic [31:0] lim;

    // Defaults: c = -2-2i at the origin escapes after one step, colour 2000+(5<<5).
    rows.push_back(row(VIEW_RESET, 0, 0, 1, 1, 1, 2160));
    rows.push_back(row(VIEW_RESET, 1023, 1023, 0, 0, 0, 0));
    rows.push_back(row(VIEW_RESET, 1023, 0, 0, 0, 0, 0));
    rows.push_back(row(VIEW_RESET, 0, 1023, 0, 0, 0, 0));
    rows.push_back(row(VIEW_RESET, 512, 512, 0, 0, 0, 0));   // c = 0, stays inside
    rows.push_back(row(VIEW_RESET, 350, 512, 0, 0, 0, 0));
    rows.push_back(row(VIEW_RESET, 341, 682, 0, 0, 0, 0));
    rows.push_back(row(VIEW_RESET, 600, 400, 0, 0, 0, 0));
    // Zero limit: no iteration, nothing escapes, no colour.
    rows.push_back(row(VIEW_NOITER, 0, 0, 1, 0, 0, 0));
    rows.push_back(row(VIEW_NOITER, 1023, 1023, 1, 0, 0, 0));
    rows.push_back(row(VIEW_NOITER, 682, 341, 1, 0, 0, 0));
    // Saturating origins and steps, start point at the extremes.
    rows.push_back(row(VIEW_EXTREME, 0, 0, 0, 0, 0, 0));
    rows.push_back(row(VIEW_EXTREME, 1023, 1023, 0, 0, 0, 0));
    rows.push_back(row(VIEW_EXTREME, 1, 1022, 0, 0, 0, 0));
    rows.push_back(row(VIEW_EXTREME, 1022, 1, 0, 0, 0, 0));
    rows.push_back(row(VIEW_EXTREME, 512, 0, 0, 0, 0, 0));
    // Deepest limit, c = 0: runs all 4095 steps, reported as inside.
    rows.push_back(row(VIEW_DEEP, 0, 0, 1, 4095, 0, 0));
    rows.push_back(row(VIEW_DEEP, 0, 0, 1, 4095, 0, 0));
    rows.push_back(row(VIEW_DEEP, 0, 0, 1, 4095, 0, 0));
    rows.push_back(row(VIEW_DEEP, 1, 0, 0, 0, 0, 0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cur_view = VIEW_RESET;
    foreach (rows[k]) begin
      if (rows[k].view != cur_view) begin
        wait_drained();
        cur_view = rows[k].view;
        case (cur_view)
          VIEW_NOITER:
            write_view(32'hE000_0000, 32'h0010_0000, 32'hE000_0000, 32'h0010_0000,
                       32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
          VIEW_EXTREME:
            write_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h0000_0FFF, 32'h8000_0000, 32'h7FFF_FFFF);
          VIEW_DEEP:
            write_view(32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000,
                       32'h0000_0FFF, 32'h0000_0000, 32'h0000_0000);
          default: ;
        endcase
      end
      want = '{col: rows[k].col, lin: rows[k].lin, iter: rows[k].iter,
               esc: rows[k].esc, colour: rows[k].colour};
      send_pixel(rows[k].col, rows[k].lin, rows[k].typed, want);
    end

    // Random views: mostly a sensible window over the set, now and then raw extremes.
    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_drained();
      lim = (p % 4 == 3) ? $urandom_range(4095, 1) : $urandom_range(120, 1);
      if (p % 4 == 3 || p == 1) lim = $urandom_range(64, 1);
      if (p % 5 == 4)
        write_view($urandom, $urandom, $urandom, $urandom, $urandom & 32'hFF, $urandom,
                   $urandom);
      else
        write_view(32'hD800_0000 + $urandom_range(32'h1000_0000, 0),
                   $urandom_range(32'h0004_0000, 32'h0000_4000),
                   32'hE000_0000 + $urandom_range(32'h1000_0000, 0),
                   $urandom_range(32'h0004_0000, 32'h0000_4000), lim,
                   (p % 3 == 2) ? $urandom_range(32'h0800_0000, 0) - 32'h0400_0000 : 32'h0,
                   (p % 3 == 2) ? $urandom_range(32'h0800_0000, 0) - 32'h0400_0000 : 32'h0);
      quiet = (p == 2);
      if (p == 5) hold_request = 1'b1;  // fill the ring while the receiver sits back
      for (int n = 0; n < RAND_PER_PHASE; n++)
        send_pixel($urandom_range(1023, 0), $urandom_range(1023, 0), 1'b0, want);
      quiet = 1'b0;
    end

    wait_drained();
    $display("%0d pixels over %0d config transactions, %0d escaped",
             pixels_checked, cfg_writes, escaped_seen);
    $display("views covered defaults, zero and full limit, saturation, random windows");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/etfp_pkg.sv
src/escape_time_fractal_pixel.sv
bench/escape_time_fractal_pixel_tb.sv
